// ===== rtl/acdp_pkg.sv =====
package acdp_pkg;

    // Store geometry
    localparam int MAX_ANCHORS = 64;
    localparam int IDX_W       = $clog2(MAX_ANCHORS);
    localparam int CNT_W       = IDX_W + 1;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP_OPEN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP_EXTEND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP_OPEN    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP_EXTEND  = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [9:0] SHORT_GAP_OPEN_RST   = 10'd5;
    localparam logic [7:0] SHORT_GAP_EXTEND_RST = 8'd2;
    localparam logic [9:0] LONG_GAP_OPEN_RST    = 10'd10;
    localparam logic [7:0] LONG_GAP_EXTEND_RST  = 8'd1;

    typedef struct packed {
        logic [19:0] anchor_position;
        logic [15:0] anchor_weight;
        logic        final_anchor;
    } anchor_t;

    typedef struct packed {
        logic [5:0]         chain_index;
        logic signed [31:0] best_score;
        logic               chain_end;
    } chain_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ROW_SETUP,
        ST_ROW_CAPT,
        ST_SCAN,
        ST_DRAIN,
        ST_ROW_WRITE,
        ST_BEST_SCAN,
        ST_BEST_DRAIN,
        ST_TRACE_WR,
        ST_TRACE_RD,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

// ===== rtl/anchor_chain_dp_two_piece_gap_core.sv =====
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid / in_ready    | anchor_t: position, weight, final flag
// out     | output    | out_valid / out_ready  | chain_t: chain index, best score, end flag
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (four gap cost registers)
//
// Flow: a non-final anchor is stored. A final anchor starts the DP over n stored
// anchors: each row reads the score memory once per earlier anchor, fills the pipeline
// and writes back; then come a best-score sweep, a traceback that pushes each chain word
// on the stack, and the emission of the chain words while out is free.
// Reset (async): control clears, gap registers load reset values; memories are not cleared.
// Stalls: out_ready low holds the output word; in_ready is high only while loading.
module anchor_chain_dp_two_piece_gap_core
    import acdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  anchor_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output chain_t                out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Memories
    logic [19:0] pos_mem   [MAX_ANCHORS];
    logic [15:0] wt_mem    [MAX_ANCHORS];
    logic [31:0] score_mem [MAX_ANCHORS];
    logic [6:0]  pred_mem  [MAX_ANCHORS];
    logic [5:0]  stack_mem [MAX_ANCHORS];

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   e_reg, e_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic               more_reg, more_next;
    logic               out_valid_reg, out_valid_next;
    logic               dp_rd_v_reg, m_v_reg, c_v_reg, k_v_reg, bs_rd_v_reg;

    // Configuration registers
    logic [9:0]         sgo_reg, lgo_reg;
    logic [7:0]         sge_reg, lge_reg;

    // Datapath registers
    logic [19:0]        pos_rd_reg;
    logic [15:0]        wt_rd_reg;
    logic [31:0]        score_rd_reg;
    logic [6:0]         pred_rd_reg;
    logic [5:0]         stack_rd_reg;
    logic [IDX_W-1:0]   rd_j_reg, m_j_reg, c_j_reg, k_j_reg;
    logic [19:0]        pos_i_reg;
    logic [15:0]        wt_i_reg;
    logic [31:0]        m1_reg, m2_reg, sw1_reg, sw2_reg, c1_reg, c2_reg, cand_reg;
    logic signed [31:0] row_score_reg, row_score_next;
    logic               row_pv_reg, row_pv_next;
    logic [IDX_W-1:0]   row_pj_reg, row_pj_next;
    logic signed [31:0] best_score_reg, best_score_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    chain_t             out_reg;

    // Handshakes and memory controls
    logic               in_fire, store_ok, dp_issue, bs_issue;
    logic [IDX_W-1:0]   pos_raddr;
    logic               row_write, stack_write, emit_issue;
    logic               pipe_busy;
    logic [31:0]        d_w, cost_w;

    assign in_fire   = in_valid && in_ready;
    assign store_ok  = (count_reg < CNT_W'(MAX_ANCHORS));
    assign pipe_busy = dp_rd_v_reg || m_v_reg || c_v_reg || k_v_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && in_data.final_anchor)
                    state_next = ST_ROW_SETUP;
            end
            ST_ROW_SETUP:
            begin
                state_next = (i_reg == '0) ? ST_ROW_WRITE : ST_ROW_CAPT;
            end
            ST_ROW_CAPT:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (j_reg == i_reg - IDX_W'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = ST_ROW_WRITE;
            end
            ST_ROW_WRITE:
            begin
                if (CNT_W'(i_reg) == n_reg - CNT_W'(1))
                    state_next = ST_BEST_SCAN;
                else
                    state_next = ST_ROW_SETUP;
            end
            ST_BEST_SCAN:
            begin
                if (CNT_W'(j_reg) == n_reg - CNT_W'(1))
                    state_next = ST_BEST_DRAIN;
            end
            ST_BEST_DRAIN:
            begin
                if (!bs_rd_v_reg)
                    state_next = ST_TRACE_WR;
            end
            ST_TRACE_WR:
            begin
                state_next = ST_TRACE_RD;
            end
            ST_TRACE_RD:
            begin
                if (pred_rd_reg[6] && (len_reg < n_reg))
                    state_next = ST_TRACE_WR;
                else
                    state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = (e_reg == '0) ? ST_LOAD : ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs and counters
    always_comb
    begin
        in_ready        = 1'b0;
        dp_issue        = 1'b0;
        bs_issue        = 1'b0;
        row_write       = 1'b0;
        stack_write     = 1'b0;
        emit_issue      = 1'b0;
        pos_raddr       = j_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        len_next        = len_reg;
        e_next          = e_reg;
        cur_next        = cur_reg;
        more_next       = more_reg;
        row_score_next  = row_score_reg;
        row_pv_next     = row_pv_reg;
        row_pj_next     = row_pj_reg;
        best_score_next = best_score_reg;
        best_idx_next   = best_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        // Fold finished candidates into the running row maximum
        if (k_v_reg && ($signed(cand_reg) > row_score_reg))
        begin
            row_score_next = $signed(cand_reg);
            row_pv_next    = 1'b1;
            row_pj_next    = k_j_reg;
        end

        // Track the first maximal score
        if (bs_rd_v_reg && ((rd_j_reg == '0) || ($signed(score_rd_reg) > best_score_reg)))
        begin
            best_score_next = $signed(score_rd_reg);
            best_idx_next   = rd_j_reg;
        end

        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    count_next = store_ok ? count_reg + CNT_W'(1) : count_reg;
                    if (in_data.final_anchor)
                    begin
                        n_next     = count_next;
                        count_next = '0;
                        i_next     = '0;
                    end
                end
            end
            ST_ROW_SETUP:
            begin
                pos_raddr      = i_reg;
                row_score_next = '0;
                row_pv_next    = 1'b0;
                row_pj_next    = '0;
                j_next         = '0;
            end
            ST_SCAN:
            begin
                dp_issue = 1'b1;
                j_next   = j_reg + IDX_W'(1);
            end
            ST_ROW_WRITE:
            begin
                row_write = 1'b1;
                if (CNT_W'(i_reg) == n_reg - CNT_W'(1))
                    j_next = '0;
                else
                    i_next = i_reg + IDX_W'(1);
            end
            ST_BEST_SCAN:
            begin
                bs_issue = 1'b1;
                j_next   = j_reg + IDX_W'(1);
            end
            ST_BEST_DRAIN:
            begin
                if (!bs_rd_v_reg)
                begin
                    cur_next = best_idx_reg;
                    len_next = '0;
                end
            end
            ST_TRACE_WR:
            begin
                stack_write = 1'b1;
                len_next    = len_reg + CNT_W'(1);
            end
            ST_TRACE_RD:
            begin
                more_next = pred_rd_reg[6];
                cur_next  = pred_rd_reg[IDX_W-1:0];
                e_next    = len_reg[IDX_W-1:0] - IDX_W'(1);
            end
            ST_EMIT_RD:
            begin
                emit_issue = !out_valid_reg || out_ready;
            end
            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                e_next         = e_reg - IDX_W'(1);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            len_reg       <= '0;
            e_reg         <= '0;
            cur_reg       <= '0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            dp_rd_v_reg   <= 1'b0;
            m_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            k_v_reg       <= 1'b0;
            bs_rd_v_reg   <= 1'b0;
            sgo_reg       <= SHORT_GAP_OPEN_RST;
            sge_reg       <= SHORT_GAP_EXTEND_RST;
            lgo_reg       <= LONG_GAP_OPEN_RST;
            lge_reg       <= LONG_GAP_EXTEND_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            len_reg       <= len_next;
            e_reg         <= e_next;
            cur_reg       <= cur_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
            dp_rd_v_reg   <= dp_issue;
            m_v_reg       <= dp_rd_v_reg;
            c_v_reg       <= m_v_reg;
            k_v_reg       <= c_v_reg;
            bs_rd_v_reg   <= bs_issue;
            // Take configuration words; drop unknown indexes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SHORT_GAP_OPEN:   sgo_reg <= cfg_data[9:0];
                    CFG_SHORT_GAP_EXTEND: sge_reg <= cfg_data[7:0];
                    CFG_LONG_GAP_OPEN:    lgo_reg <= cfg_data[9:0];
                    CFG_LONG_GAP_EXTEND:  lge_reg <= cfg_data[7:0];
                    default:              sgo_reg <= sgo_reg;
                endcase
            end
        end
    end

    // Gap cost pipeline arithmetic
    assign d_w    = {12'd0, pos_i_reg} - {12'd0, pos_rd_reg} - 32'd1;
    assign cost_w = ($signed(c1_reg) < $signed(c2_reg)) ? c1_reg : c2_reg;

    // Datapath registers
    always_ff @(posedge clk)
    begin
        row_score_reg  <= row_score_next;
        row_pv_reg     <= row_pv_next;
        row_pj_reg     <= row_pj_next;
        best_score_reg <= best_score_next;
        best_idx_reg   <= best_idx_next;
        rd_j_reg       <= j_reg;
        // Capture anchor i for the row
        if (state_reg == ST_ROW_CAPT)
        begin
            pos_i_reg <= pos_rd_reg;
            wt_i_reg  <= wt_rd_reg;
        end
        // Stage 1: products and score plus weight
        m1_reg  <= d_w * {24'd0, sge_reg};
        m2_reg  <= d_w * {24'd0, lge_reg};
        sw1_reg <= score_rd_reg + {16'd0, wt_i_reg};
        m_j_reg <= rd_j_reg;
        // Stage 2: both piece costs
        c1_reg  <= {22'd0, sgo_reg} + m1_reg;
        c2_reg  <= {22'd0, lgo_reg} + m2_reg;
        sw2_reg <= sw1_reg;
        c_j_reg <= m_j_reg;
        // Stage 3: candidate with the cheaper piece
        cand_reg <= sw2_reg - cost_w;
        k_j_reg  <= c_j_reg;
        // Load the output word
        if (state_reg == ST_EMIT_LD)
        begin
            out_reg.chain_index <= stack_rd_reg;
            out_reg.best_score  <= best_score_reg;
            out_reg.chain_end   <= (e_reg == '0);
        end
    end

    // Anchor memories
    always_ff @(posedge clk)
    begin
        if (in_fire && store_ok)
        begin
            pos_mem[count_reg[IDX_W-1:0]] <= in_data.anchor_position;
            wt_mem[count_reg[IDX_W-1:0]]  <= in_data.anchor_weight;
        end
        pos_rd_reg <= pos_mem[pos_raddr];
        wt_rd_reg  <= wt_mem[i_reg];
    end

    // Score and predecessor memories
    always_ff @(posedge clk)
    begin
        if (row_write)
        begin
            score_mem[i_reg] <= row_score_reg;
            pred_mem[i_reg]  <= {row_pv_reg, 6'(row_pj_reg)};
        end
        score_rd_reg <= score_mem[j_reg];
        pred_rd_reg  <= pred_mem[cur_reg];
    end

    // Chain stack memory
    always_ff @(posedge clk)
    begin
        if (stack_write)
            stack_mem[len_reg[IDX_W-1:0]] <= 6'(cur_reg);
        if (emit_issue)
            stack_rd_reg <= stack_mem[e_reg];
    end

endmodule

// ===== sim/chain_checker.sv =====
module chain_checker
    import acdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  anchor_t               in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  chain_t                out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Gap cost registers as the block should hold them
    logic [9:0]  short_open;
    logic [7:0]  short_ext;
    logic [9:0]  long_open;
    logic [7:0]  long_ext;

    // Anchors of the set being loaded
    logic [19:0] anchor_pos [MAX_ANCHORS];
    logic [15:0] anchor_wt  [MAX_ANCHORS];
    int          anchors_loaded;

    // Chain words still owed by the block, oldest first
    chain_t      chain_words [$];
    chain_t      want;

    // Score the loaded set, trace the best chain and queue its words
    task automatic predict_chain(input int n);
        logic [31:0] score    [MAX_ANCHORS];
        logic        has_pred [MAX_ANCHORS];
        logic [5:0]  pred     [MAX_ANCHORS];
        logic [5:0]  path     [$];
        logic [31:0] gap_len;
        logic [31:0] cost_short;
        logic [31:0] cost_long;
        logic [31:0] cost;
        logic [31:0] cand;
        int          best;
        int          cur;
        bit          more;
        chain_t      word;

        score[0]    = '0;
        has_pred[0] = 1'b0;
        pred[0]     = '0;
        for (int i = 1; i < n; i++)
        begin
            score[i]    = '0;
            has_pred[i] = 1'b0;
            pred[i]     = '0;
            for (int j = 0; j < i; j++)
            begin
                // all terms wrap at 32 bits; compare as signed
                gap_len    = 32'(anchor_pos[i]) - 32'(anchor_pos[j]) - 32'd1;
                cost_short = 32'(short_open) + 32'(short_ext) * gap_len;
                cost_long  = 32'(long_open) + 32'(long_ext) * gap_len;
                cost       = ($signed(cost_short) < $signed(cost_long)) ? cost_short
                                                                        : cost_long;
                cand       = score[j] + 32'(anchor_wt[i]) - cost;
                if ($signed(cand) > $signed(score[i]))
                begin
                    score[i]    = cand;
                    has_pred[i] = 1'b1;
                    pred[i]     = 6'(j);
                end
            end
        end

        // first index holding the top score wins ties
        best = 0;
        for (int i = 1; i < n; i++)
            if ($signed(score[i]) > $signed(score[best]))
                best = i;

        // walk back through predecessors, building forward order
        cur  = best;
        more = 1'b1;
        while (more && path.size() < n)
        begin
            path.push_front(6'(cur));
            more = has_pred[cur];
            cur  = pred[cur];
        end

        foreach (path[k])
        begin
            word.chain_index = path[k];
            word.best_score  = score[best];
            word.chain_end   = (k == path.size() - 1);
            chain_words.insert(chain_words.size(), word);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_open     = SHORT_GAP_OPEN_RST;
            short_ext      = SHORT_GAP_EXTEND_RST;
            long_open      = LONG_GAP_OPEN_RST;
            long_ext       = LONG_GAP_EXTEND_RST;
            anchors_loaded = 0;
            mismatch_count = 0;
            chain_words.delete();
            words_pending  = 0;
        end
        else
        begin
            // Register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SHORT_GAP_OPEN:   short_open = cfg_data[9:0];
                    CFG_SHORT_GAP_EXTEND: short_ext  = cfg_data[7:0];
                    CFG_LONG_GAP_OPEN:    long_open  = cfg_data[9:0];
                    CFG_LONG_GAP_EXTEND:  long_ext   = cfg_data[7:0];
                    default: ;
                endcase
            end

            // Store the anchor unless the set is full; a final word starts scoring
            if (in_valid && in_ready)
            begin
                if (anchors_loaded < MAX_ANCHORS)
                begin
                    anchor_pos[anchors_loaded] = in_data.anchor_position;
                    anchor_wt[anchors_loaded]  = in_data.anchor_weight;
                    anchors_loaded++;
                end
                if (in_data.final_anchor)
                begin
                    predict_chain(anchors_loaded);
                    anchors_loaded = 0;
                end
            end

            // Compare each chain word with the oldest one owed
            if (out_valid && out_ready)
            begin
                if (chain_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected chain word: idx %0d score %0d end %0b",
                                 out_data.chain_index, out_data.best_score,
                                 out_data.chain_end);
                end
                else
                begin
                    want = chain_words.pop_front();
                    if (out_data.chain_index !== want.chain_index ||
                        out_data.best_score !== want.best_score ||
                        out_data.chain_end !== want.chain_end)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"chain word mismatch: expected idx %0d score %0d ",
                                      "end %0b, got idx %0d score %0d end %0b"},
                                     want.chain_index, want.best_score, want.chain_end,
                                     out_data.chain_index, out_data.best_score,
                                     out_data.chain_end);
                    end
                end
            end
            words_pending = chain_words.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import acdp_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    anchor_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    chain_t                out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int chain_errors;
    int chain_pending;
    bit gaps_on = 1'b1;

    always #5ns clk = ~clk;

    anchor_chain_dp_two_piece_gap_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    chain_checker i_chain_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (chain_errors),
        .words_pending  (chain_pending)
    );

    // Hold one anchor word until accepted; drop valid after a final word
    task automatic send_anchor(input logic [19:0] pos, input logic [15:0] wt,
                               input logic fin);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid                <= 1'b1;
        in_data.anchor_position <= pos;
        in_data.anchor_weight   <= wt;
        in_data.final_anchor    <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (fin)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Write one register word
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every chain word is out and the block has gone back to loading
    task automatic settle();
        @(negedge clk);
        while (chain_pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    // Receiver stalls in bursts
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall == 0 && gaps_on && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int          random_sent;
        int          set_len;
        int          style;
        bit          big_done;
        logic [19:0] pos;
        logic [15:0] wt;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;

        random_sent = 0;
        big_done    = 1'b0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Single anchor under reset costs
        send_anchor(20'd0, 16'd0, 1'b1);
        // Position extremes, then a tight heavy pair
        send_anchor(20'd0, 16'hFFFF, 1'b0);
        send_anchor(20'hFFFFF, 16'hFFFF, 1'b0);
        send_anchor(20'd100, 16'hFFFF, 1'b0);
        send_anchor(20'd101, 16'hFFFF, 1'b1);
        settle();

        // Free gaps: all-equal scores tie back to the first anchor
        write_reg(CFG_SHORT_GAP_OPEN, '0);
        write_reg(CFG_SHORT_GAP_EXTEND, '0);
        write_reg(CFG_LONG_GAP_OPEN, '0);
        write_reg(CFG_LONG_GAP_EXTEND, '0);
        send_anchor(20'd5, 16'd0, 1'b0);
        send_anchor(20'd5, 16'd0, 1'b0);
        send_anchor(20'd5, 16'd0, 1'b1);
        send_anchor(20'd10, 16'd7, 1'b0);
        send_anchor(20'd20, 16'd7, 1'b0);
        send_anchor(20'd30, 16'd7, 1'b1);
        settle();

        // Top costs with masked-off data bits, plus a write to an unused index
        write_reg(CFG_SHORT_GAP_OPEN, '1);
        write_reg(CFG_SHORT_GAP_EXTEND, '1);
        write_reg(CFG_LONG_GAP_OPEN, '1);
        write_reg(CFG_LONG_GAP_EXTEND, '1);
        write_reg(CFG_IDX_W'($urandom_range(CFG_LONG_GAP_EXTEND + 1, 2**CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom()));
        // Backward jumps give negative gap lengths and wrapping products
        send_anchor(20'hFFFFF, 16'hFFFF, 1'b0);
        send_anchor(20'd0, 16'hFFFF, 1'b0);
        send_anchor(20'h80000, 16'd0, 1'b0);
        send_anchor(20'd3, 16'd1, 1'b1);
        settle();

        // Reset costs again, descending positions
        write_reg(CFG_SHORT_GAP_OPEN, CFG_DATA_W'(SHORT_GAP_OPEN_RST));
        write_reg(CFG_SHORT_GAP_EXTEND, CFG_DATA_W'(SHORT_GAP_EXTEND_RST));
        write_reg(CFG_LONG_GAP_OPEN, CFG_DATA_W'(LONG_GAP_OPEN_RST));
        write_reg(CFG_LONG_GAP_EXTEND, CFG_DATA_W'(LONG_GAP_EXTEND_RST));
        send_anchor(20'd1000, 16'd50, 1'b0);
        send_anchor(20'd900, 16'd50, 1'b0);
        send_anchor(20'd800, 16'd50, 1'b0);
        send_anchor(20'd700, 16'd50, 1'b1);

        // Random sets, mostly ordered runs, with cost changes between some
        while (random_sent < 211)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                settle();
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 5) == 0)
                        idx = CFG_IDX_W'($urandom_range(CFG_LONG_GAP_EXTEND + 1,
                                                        2**CFG_IDX_W - 1));
                    else
                        idx = CFG_IDX_W'($urandom_range(CFG_SHORT_GAP_OPEN,
                                                        CFG_LONG_GAP_EXTEND));
                    case ($urandom_range(0, 3))
                        0:       data = '0;
                        1:       data = '1;
                        2:       data = CFG_DATA_W'($urandom_range(0, 12));
                        default: data = CFG_DATA_W'($urandom());
                    endcase
                    write_reg(idx, data);
                end
            end

            // one oversized set overflows the store
            if (!big_done && random_sent >= 60)
            begin
                set_len  = MAX_ANCHORS + $urandom_range(1, 3);
                big_done = 1'b1;
            end
            else
                set_len = $urandom_range(1, 10);

            style = $urandom_range(0, 9);
            pos   = 20'($urandom());
            for (int k = 0; k < set_len; k++)
            begin
                if (k > 0)
                begin
                    if (style <= 6)
                        pos = pos + 20'($urandom_range(1, 40));
                    else if (style <= 8)
                        pos = 20'($urandom());
                    else
                        pos = pos - 20'($urandom_range(1, 5000));
                end
                case ($urandom_range(0, 5))
                    0:       wt = '0;
                    1:       wt = '1;
                    2, 3:    wt = 16'($urandom_range(1, 100));
                    default: wt = 16'($urandom());
                endcase
                send_anchor(pos, wt, k == set_len - 1);
                random_sent++;
                gaps_on = (random_sent < 175);
            end
        end

        // Drain and give the verdict
        @(negedge clk);
        while (chain_pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (chain_errors == 0 && chain_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
